>>> rtl/core/lsra_pkg.sv
`default_nettype none

package lsra_pkg;

  localparam int NUM_REGS  = 3;
  localparam int POS_BITS  = 16;
  localparam int TAG_BITS  = 16;
  localparam int REG_BITS  = 2;
  localparam int SLOT_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int KEY_BITS  = 2 * POS_BITS;

  localparam int IN_DATA_BITS  = 3 * POS_BITS;
  localparam int IN_DATA_BYTES = (IN_DATA_BITS + 7) / 8;
  localparam int OUT_FIELD_BITS = TAG_BITS + REG_BITS;
  localparam int OUT_DATA_BYTES = (OUT_FIELD_BITS + 7) / 8;
  localparam int OUT_PAD_BITS   = 8 * OUT_DATA_BYTES - OUT_FIELD_BITS;

  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [REG_BITS-1:0]  reg_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [KEY_BITS-1:0]  key_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_ALLOC,
    ST_SEARCH,
    ST_RESOLVE,
    ST_SPILL_OLD
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/lsra_cmp.sv
`default_nettype none

// Shared magnitude comparator. Keys are {end, start} pairs, so one unsigned
// compare covers the expiry test, the spill candidate order and the final
// steal decision.
module lsra_cmp (
  input  wire lsra_pkg::key_t a,
  input  wire lsra_pkg::key_t b,
  output logic                lt
);

  assign lt = (a < b);

endmodule

`default_nettype wire

>>> rtl/core/linear_scan_register_allocator.sv
`default_nettype none

// Linear-scan register allocator for a small register file.
// The input channel takes one live interval per word: tag, start and end
// point in tdata, and the new-function flag in tuser, which clears the active
// set and frees every register before the interval is handled. Intervals are
// expected sorted by start point.
// The output channel returns one word for a grant or a spill, and two words
// for a steal (the new interval with the taken register, then the displaced
// interval marked spilled). tlast marks the final word of each interval.
// A single comparator is stepped over the active slots, once for expiry and,
// when no register is free, once more for the spill candidate. Each interval
// passes through the expiry scan and the allocation step and, when no
// register is free, through the candidate search, the resolve step and, for
// a steal, the step that sends the displaced interval.
// Results leave through an output register. When the receiver stalls, the
// sequencer waits at the step that produces the next word and holds the
// interval. Reset empties the active set and marks every register free.
module linear_scan_register_allocator (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [47:0] s_tdata,   // interval_tag, start_point, end_point
  input  wire        s_tuser,   // new_function
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [23:0] m_tdata,  // result_tag, reg_number, zero padding
  output logic       m_tuser,   // spilled
  output logic       m_tlast    // last_result
);

  lsra_pkg::state_t state, state_next;
  lsra_pkg::slot_t  idx, idx_next;
  lsra_pkg::slot_t  cand, cand_next;
  logic             cand_ok, cand_ok_next;
  lsra_pkg::tag_t   cur_tag, cur_tag_next;
  lsra_pkg::pos_t   cur_st, cur_st_next;
  lsra_pkg::pos_t   cur_en, cur_en_next;
  lsra_pkg::tag_t   old_tag, old_tag_next;

  logic             active_valid [lsra_pkg::NUM_REGS];
  logic             active_valid_next [lsra_pkg::NUM_REGS];
  lsra_pkg::pos_t   active_start [lsra_pkg::NUM_REGS];
  lsra_pkg::pos_t   active_start_next [lsra_pkg::NUM_REGS];
  lsra_pkg::pos_t   active_end [lsra_pkg::NUM_REGS];
  lsra_pkg::pos_t   active_end_next [lsra_pkg::NUM_REGS];
  lsra_pkg::tag_t   active_tag [lsra_pkg::NUM_REGS];
  lsra_pkg::tag_t   active_tag_next [lsra_pkg::NUM_REGS];
  lsra_pkg::reg_t   active_reg [lsra_pkg::NUM_REGS];
  lsra_pkg::reg_t   active_reg_next [lsra_pkg::NUM_REGS];
  logic             reg_free [lsra_pkg::NUM_REGS];
  logic             reg_free_next [lsra_pkg::NUM_REGS];

  logic             out_valid, out_valid_next;
  lsra_pkg::tag_t   out_tag, out_tag_next;
  lsra_pkg::reg_t   out_reg, out_reg_next;
  logic             out_spill, out_spill_next;
  logic             out_last, out_last_next;

  lsra_pkg::key_t   cmp_a, cmp_b;
  logic             cmp_lt;

  lsra_pkg::slot_t  free_idx, slot_idx;
  logic             free_found, slot_found;
  logic             out_room;

  lsra_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign out_room = !out_valid || m_tready;
  assign s_tready = (state == lsra_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{lsra_pkg::OUT_PAD_BITS{1'b0}}, out_reg, out_tag};
  assign m_tuser  = out_spill;
  assign m_tlast  = out_last;

  // Lowest free register and lowest empty slot.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    slot_idx   = '0;
    slot_found = 1'b0;
    for (int i = lsra_pkg::NUM_REGS - 1; i >= 0; i--) begin
      if (reg_free[i]) begin
        free_idx   = lsra_pkg::SLOT_BITS'(i);
        free_found = 1'b1;
      end
      if (!active_valid[i]) begin
        slot_idx   = lsra_pkg::SLOT_BITS'(i);
        slot_found = 1'b1;
      end
    end
  end

  // Comparator operands for each step.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    unique case (state)
      lsra_pkg::ST_EXPIRE: begin
        cmp_a = {active_end[idx], {lsra_pkg::POS_BITS{1'b0}}};
        cmp_b = {cur_st, {lsra_pkg::POS_BITS{1'b0}}};
      end
      lsra_pkg::ST_SEARCH: begin
        cmp_a = {active_end[idx], active_start[idx]};
        cmp_b = {active_end[cand], active_start[cand]};
      end
      lsra_pkg::ST_RESOLVE: begin
        // True when the candidate ends strictly after the new interval.
        cmp_a = {cur_en, {lsra_pkg::POS_BITS{1'b1}}};
        cmp_b = {active_end[cand], {lsra_pkg::POS_BITS{1'b0}}};
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    cand_next         = cand;
    cand_ok_next      = cand_ok;
    cur_tag_next      = cur_tag;
    cur_st_next       = cur_st;
    cur_en_next       = cur_en;
    old_tag_next      = old_tag;
    active_valid_next = active_valid;
    active_start_next = active_start;
    active_end_next   = active_end;
    active_tag_next   = active_tag;
    active_reg_next   = active_reg;
    reg_free_next     = reg_free;
    out_valid_next    = out_valid && !m_tready;
    out_tag_next      = out_tag;
    out_reg_next      = out_reg;
    out_spill_next    = out_spill;
    out_last_next     = out_last;

    unique case (state)
      lsra_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cur_tag_next = s_tdata[lsra_pkg::TAG_BITS-1:0];
          cur_st_next  = s_tdata[lsra_pkg::TAG_BITS +: lsra_pkg::POS_BITS];
          cur_en_next  = s_tdata[lsra_pkg::TAG_BITS + lsra_pkg::POS_BITS +:
                                 lsra_pkg::POS_BITS];
          if (s_tuser) begin
            for (int i = 0; i < lsra_pkg::NUM_REGS; i++) begin
              active_valid_next[i] = 1'b0;
              reg_free_next[i]     = 1'b1;
            end
          end
          idx_next   = '0;
          state_next = lsra_pkg::ST_EXPIRE;
        end
      end

      lsra_pkg::ST_EXPIRE: begin
        if (active_valid[idx] && cmp_lt) begin
          active_valid_next[idx] = 1'b0;
          if (active_reg[idx] < lsra_pkg::REG_BITS'(lsra_pkg::NUM_REGS)) begin
            reg_free_next[active_reg[idx][lsra_pkg::SLOT_BITS-1:0]] = 1'b1;
          end
        end
        if (idx == lsra_pkg::SLOT_BITS'(lsra_pkg::NUM_REGS - 1)) begin
          state_next = lsra_pkg::ST_ALLOC;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      lsra_pkg::ST_ALLOC: begin
        if (free_found && slot_found) begin
          if (out_room) begin
            reg_free_next[free_idx]     = 1'b0;
            active_valid_next[slot_idx] = 1'b1;
            active_start_next[slot_idx] = cur_st;
            active_end_next[slot_idx]   = cur_en;
            active_tag_next[slot_idx]   = cur_tag;
            active_reg_next[slot_idx]   = lsra_pkg::REG_BITS'(free_idx);
            out_valid_next = 1'b1;
            out_tag_next   = cur_tag;
            out_reg_next   = lsra_pkg::REG_BITS'(free_idx);
            out_spill_next = 1'b0;
            out_last_next  = 1'b1;
            state_next     = lsra_pkg::ST_IDLE;
          end
        end else begin
          idx_next     = '0;
          cand_ok_next = 1'b0;
          state_next   = lsra_pkg::ST_SEARCH;
        end
      end

      lsra_pkg::ST_SEARCH: begin
        // Later end wins; on equal ends the later start, then the higher slot.
        if (active_valid[idx] && (!cand_ok || !cmp_lt)) begin
          cand_next    = idx;
          cand_ok_next = 1'b1;
        end
        if (idx == lsra_pkg::SLOT_BITS'(lsra_pkg::NUM_REGS - 1)) begin
          state_next = lsra_pkg::ST_RESOLVE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      lsra_pkg::ST_RESOLVE: begin
        if (out_room) begin
          out_valid_next = 1'b1;
          out_tag_next   = cur_tag;
          if (cand_ok && cmp_lt) begin
            old_tag_next            = active_tag[cand];
            active_start_next[cand] = cur_st;
            active_end_next[cand]   = cur_en;
            active_tag_next[cand]   = cur_tag;
            out_reg_next   = active_reg[cand];
            out_spill_next = 1'b0;
            out_last_next  = 1'b0;
            state_next     = lsra_pkg::ST_SPILL_OLD;
          end else begin
            out_reg_next   = '0;
            out_spill_next = 1'b1;
            out_last_next  = 1'b1;
            state_next     = lsra_pkg::ST_IDLE;
          end
        end
      end

      lsra_pkg::ST_SPILL_OLD: begin
        if (out_room) begin
          out_valid_next = 1'b1;
          out_tag_next   = old_tag;
          out_reg_next   = '0;
          out_spill_next = 1'b1;
          out_last_next  = 1'b1;
          state_next     = lsra_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lsra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < lsra_pkg::NUM_REGS; i++) begin
        active_valid[i] <= 1'b0;
        reg_free[i]     <= 1'b1;
      end
    end else begin
      out_valid    <= out_valid_next;
      active_valid <= active_valid_next;
      reg_free     <= reg_free_next;
    end
  end

  always_ff @(posedge clk) begin
    idx          <= idx_next;
    cand         <= cand_next;
    cand_ok      <= cand_ok_next;
    cur_tag      <= cur_tag_next;
    cur_st       <= cur_st_next;
    cur_en       <= cur_en_next;
    old_tag      <= old_tag_next;
    active_start <= active_start_next;
    active_end   <= active_end_next;
    active_tag   <= active_tag_next;
    active_reg   <= active_reg_next;
    out_tag      <= out_tag_next;
    out_reg      <= out_reg_next;
    out_spill    <= out_spill_next;
    out_last     <= out_last_next;
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    logic           nf;
    lsra_pkg::tag_t tag;
    lsra_pkg::pos_t st;
    lsra_pkg::pos_t en;
    bit             drain;
  } interval_t;

  typedef struct {
    lsra_pkg::tag_t tag;
    lsra_pkg::reg_t rnum;
    logic           spill;
    logic           last;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [47:0] s_tdata = '0;   // interval_tag, start_point, end_point
  logic        s_tuser = 1'b0; // new_function
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [23:0] m_tdata;        // result_tag, reg_number, zero padding
  wire         m_tuser;        // spilled
  wire         m_tlast;        // last_result

  interval_t     intervals_to_send[$];
  alloc_result_t alloc_expect[$];

  // Shadow copy of the allocator's active set and register pool.
  logic           act_valid[lsra_pkg::NUM_REGS];
  lsra_pkg::pos_t act_start[lsra_pkg::NUM_REGS];
  lsra_pkg::pos_t act_end[lsra_pkg::NUM_REGS];
  lsra_pkg::tag_t act_tag[lsra_pkg::NUM_REGS];
  lsra_pkg::reg_t act_reg[lsra_pkg::NUM_REGS];
  logic           reg_idle[lsra_pkg::NUM_REGS];

  int  fail_count = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  drv_burst = 1'b0;
  bit  rcv_burst = 1'b0;

  linear_scan_register_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic void clear_pool();
    for (int k = 0; k < lsra_pkg::NUM_REGS; k++) begin
      act_valid[k] = 1'b0;
      act_start[k] = '0;
      act_end[k] = '0;
      act_tag[k] = '0;
      act_reg[k] = '0;
      reg_idle[k] = 1'b1;
    end
  endfunction

  function automatic alloc_result_t make_result(lsra_pkg::tag_t tag, lsra_pkg::reg_t rnum,
                                                logic spill, logic last);
    alloc_result_t r;
    r.tag = tag;
    r.rnum = rnum;
    r.spill = spill;
    r.last = last;
    return r;
  endfunction

  function automatic void predict_allocation(logic nf, lsra_pkg::tag_t tag,
                                             lsra_pkg::pos_t st, lsra_pkg::pos_t en);
    int             rsel;
    int             slot;
    int             cand;
    lsra_pkg::tag_t old_tag;
    lsra_pkg::reg_t old_reg;
    rsel = -1;
    slot = -1;
    cand = -1;
    if (nf) clear_pool();
    for (int k = 0; k < lsra_pkg::NUM_REGS; k++) begin
      if (act_valid[k] && act_end[k] < st) begin
        act_valid[k] = 1'b0;
        if (act_reg[k] < lsra_pkg::NUM_REGS) reg_idle[act_reg[k]] = 1'b1;
      end
    end
    for (int k = lsra_pkg::NUM_REGS - 1; k >= 0; k--) begin
      if (reg_idle[k]) rsel = k;
      if (!act_valid[k]) slot = k;
    end
    if (rsel >= 0 && slot >= 0) begin
      reg_idle[rsel] = 1'b0;
      act_valid[slot] = 1'b1;
      act_start[slot] = st;
      act_end[slot] = en;
      act_tag[slot] = tag;
      act_reg[slot] = lsra_pkg::reg_t'(rsel);
      alloc_expect.push_back(make_result(tag, lsra_pkg::reg_t'(rsel), 1'b0, 1'b1));
      return;
    end
    // Every register is taken: the entry living longest is the victim if it ends after the new interval.
    for (int k = 0; k < lsra_pkg::NUM_REGS; k++) begin
      if (act_valid[k]) begin
        if (cand < 0 || act_end[k] > act_end[cand] ||
            (act_end[k] == act_end[cand] && act_start[k] >= act_start[cand]))
          cand = k;
      end
    end
    if (cand >= 0 && act_end[cand] > en) begin
      old_tag = act_tag[cand];
      old_reg = act_reg[cand];
      act_start[cand] = st;
      act_end[cand] = en;
      act_tag[cand] = tag;
      alloc_expect.push_back(make_result(tag, old_reg, 1'b0, 1'b0));
      alloc_expect.push_back(make_result(old_tag, '0, 1'b1, 1'b1));
    end else begin
      alloc_expect.push_back(make_result(tag, '0, 1'b1, 1'b1));
    end
  endfunction

  // Mostly back-to-back, some short gaps and a few long ones.
  function automatic int pick_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic add_interval(logic nf, int tag, int st, int en, bit drain);
    interval_t it;
    it.nf = nf;
    it.tag = lsra_pkg::tag_t'(tag);
    it.st = lsra_pkg::pos_t'(st);
    it.en = lsra_pkg::pos_t'(en);
    it.drain = drain;
    intervals_to_send.push_back(it);
  endtask

  initial begin
    clear_pool();
  end

  // Driver
  always @(posedge clk) begin
    logic      fire;
    logic      nxt_valid;
    interval_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
      hold_left = 0;
    end else begin
      fire = s_tvalid && s_tready;
      nxt_valid = s_tvalid;
      if (fire) begin
        predict_allocation(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
        if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
        hold_left = pick_gap(drv_burst);
      end
      if (!s_tvalid || fire) begin
        nxt_valid = 1'b0;
        if (hold_left > 0) begin
          hold_left--;
        end else if (intervals_to_send.size() > 0 &&
                     (!intervals_to_send[0].drain || alloc_expect.size() == 0)) begin
          it = intervals_to_send.pop_front();
          s_tdata <= {it.en, it.st, it.tag};
          s_tuser <= it.nf;
          nxt_valid = 1'b1;
        end
        s_tvalid <= nxt_valid;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (alloc_expect.size() == 0) begin
          $error("unexpected output word: tag %h reg %0d spilled %b last %b",
                 m_tdata[15:0], m_tdata[17:16], m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = alloc_expect.pop_front();
          if (m_tdata[15:0] !== want.tag) begin
            $error("result_tag: expected %h, got %h", want.tag, m_tdata[15:0]);
            fail_count++;
          end
          if (m_tdata[17:16] !== want.rnum) begin
            $error("reg_number: expected %0d, got %0d", want.rnum, m_tdata[17:16]);
            fail_count++;
          end
          if (m_tuser !== want.spill) begin
            $error("spilled: expected %b, got %b", want.spill, m_tuser);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_result: expected %b, got %b", want.last, m_tlast);
            fail_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) rcv_burst = !rcv_burst;
        stall_left = pick_gap(rcv_burst);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any word moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** linear_scan_register_allocator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int random_items;
    int n_len;
    int cursor;
    int span;
    int prev_st;
    int prev_en;
    int en;
    random_items = 0;

    // Grants, then a steal from the longest-living entry, then equal ends.
    add_interval(1'b1, 16'h0000, 0, 0, 1'b0);
    add_interval(1'b0, 16'hFFFF, 0, 65535, 1'b0);
    add_interval(1'b0, 16'h1234, 0, 10, 1'b0);
    add_interval(1'b0, 16'h5555, 0, 100, 1'b0);
    add_interval(1'b0, 16'hAAAA, 0, 100, 1'b0);
    add_interval(1'b0, 16'h0F0F, 1, 5, 1'b0);
    // Identical candidates: the highest slot gives up its register.
    add_interval(1'b1, 16'h00A1, 10, 50, 1'b1);
    add_interval(1'b0, 16'h00B2, 10, 50, 1'b0);
    add_interval(1'b0, 16'h00C3, 10, 50, 1'b0);
    add_interval(1'b0, 16'h00D4, 10, 20, 1'b0);
    add_interval(1'b0, 16'h00E5, 10, 60, 1'b0);
    // End before start, then an out-of-order start.
    add_interval(1'b1, 16'h7000, 500, 400, 1'b0);
    add_interval(1'b0, 16'h7001, 450, 460, 1'b0);
    add_interval(1'b0, 16'h7002, 100, 200, 1'b0);
    add_interval(1'b0, 16'h7003, 100, 50, 1'b0);
    add_interval(1'b0, 16'h7004, 0, 65535, 1'b0);
    // Top of the position range.
    add_interval(1'b1, 16'h8000, 65535, 65535, 1'b0);
    add_interval(1'b0, 16'h8001, 65535, 65535, 1'b0);
    add_interval(1'b0, 16'h8002, 65535, 65535, 1'b0);
    add_interval(1'b0, 16'h8003, 65535, 65535, 1'b0);
    add_interval(1'b0, 16'h8004, 65534, 65535, 1'b0);
    add_interval(1'b1, 16'hFFFF, 65535, 0, 1'b0);

    while (random_items < 1050) begin
      if ($urandom_range(0, 99) < 80) begin
        // A well-formed function body: starts ascending, ties ordered by end.
        n_len = $urandom_range(3, 24);
        cursor = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 4000);
        prev_st = -1;
        prev_en = 0;
        for (int k = 0; k < n_len; k++) begin
          if (k > 0) cursor = (cursor + $urandom_range(0, 6) > 65535) ? 65535
                              : cursor + $urandom_range(0, 6);
          span = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000)
                                             : $urandom_range(0, 15);
          en = (cursor + span > 65535) ? 65535 : cursor + span;
          if (cursor == prev_st && en < prev_en) en = prev_en;
          add_interval(k == 0, $urandom_range(0, 65535), cursor, en,
                       $urandom_range(0, 199) == 0);
          prev_st = cursor;
          prev_en = en;
          random_items++;
        end
      end else begin
        add_interval($urandom_range(0, 3) == 0, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0);
        random_items++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (intervals_to_send.size() > 0 || s_tvalid) @(posedge clk);
    while (alloc_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** linear_scan_register_allocator: PASSED **");
    end else begin
      $display("** linear_scan_register_allocator: FAILED **");
    end
    $finish;
  end

endmodule

>>> linear_scan_register_allocator.f
rtl/core/lsra_pkg.sv
rtl/core/lsra_cmp.sv
rtl/core/linear_scan_register_allocator.sv
tb/testbench.sv
